// ===== rtl/core/bpc_pkg.sv =====
// Shared types and constants for the button press classifier.
package bpc_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int DEB_W      = 10;
  localparam int LONG_W     = 16;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET   = DEB_W'(25);
  localparam logic [LONG_W-1:0] LONG_PRESS_RESET = LONG_W'(5000);

  // Pin level that means the button is down (active low).
  localparam logic PIN_PRESSED = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TICKS   = CFG_IDX_W'(0),
    REG_LONG_PRESS_TICKS = CFG_IDX_W'(1)
  } cfg_reg_t;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ticks;
    logic [LONG_W-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic pressed;
    logic short_press;
    logic long_press;
  } result_t;

endpackage

// ===== rtl/core/bpc_sample_if.sv =====
// Input channel: one pin sample per item.
interface bpc_sample_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink (input valid, input pin_level, output ready);
endinterface

// ===== rtl/core/bpc_result_if.sv =====
// Output channel: debounced state and press events per item.
interface bpc_result_if;
  logic valid;
  logic ready;
  logic pressed;
  logic short_press;
  logic long_press;

  modport source (output valid, output pressed, output short_press, output long_press,
                  input ready);
  modport sink (input valid, input pressed, input short_press, input long_press,
                output ready);
endinterface

// ===== rtl/core/bpc_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface bpc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bpc_pkg::CFG_IDX_W-1:0]   index;
  logic [bpc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/button_press_classifier_unit.sv =====
// Button press classifier top level: input register, classifier, result register.
//
//   channel   role   payload
//   sample    sink   pin_level
//   result    source pressed, short_press, long_press
//   cfg       sink   index, data (0 debounce_ticks, 1 long_press_ticks)
//
// One item per cycle while the result is not stalled; the accepted sample is held in the
// input register and its result in the result register.
// The input register feeds the classifier state update, which loads the result register.
// A stalled result holds the input register; at most one more sample is taken while stalled.
// Synchronous reset clears both stages and the press state, and loads the configuration defaults.
module button_press_classifier_unit #(
  parameter int AGE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  bpc_sample_if.sink    sample,
  bpc_result_if.source  result,
  bpc_cfg_if.sink       cfg
);
  import bpc_pkg::*;

  cfg_t    regs;
  result_t res;

  logic    in_valid;
  logic    in_pin;
  logic    out_valid;
  result_t out_res;
  logic    advance;

  assign advance      = in_valid && (!out_valid || result.ready);
  assign sample.ready = !in_valid || advance;

  bpc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  bpc_classify #(
    .AGE_BITS (AGE_BITS)
  ) u_classify (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .pin_level (in_pin),
    .regs      (regs),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_pin <= sample.pin_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign result.valid       = out_valid;
  assign result.pressed     = out_res.pressed;
  assign result.short_press = out_res.short_press;
  assign result.long_press  = out_res.long_press;

endmodule

// ===== rtl/core/bpc_cfg_regs.sv =====
// Configuration registers for debounce time and long-press threshold.
module bpc_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  bpc_cfg_if.sink        cfg,
  output bpc_pkg::cfg_t  regs
);
  import bpc_pkg::*;

  cfg_t regs_q;

  assign cfg.ready = 1'b1;
  assign regs      = regs_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs_q.debounce_ticks   <= DEBOUNCE_RESET;
      regs_q.long_press_ticks <= LONG_PRESS_RESET;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_DEBOUNCE_TICKS:   regs_q.debounce_ticks   <= cfg.data[DEB_W-1:0];
        REG_LONG_PRESS_TICKS: regs_q.long_press_ticks <= cfg.data[LONG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/bpc_classify.sv =====
// Debounce and press classification state, advanced once per item.
module bpc_classify #(
  parameter int AGE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              pin_level,
  input  bpc_pkg::cfg_t     regs,
  output bpc_pkg::result_t  res
);
  import bpc_pkg::*;

  localparam int CMP_W = (AGE_BITS > LONG_W) ? AGE_BITS : LONG_W;

  logic                raw_last, raw_last_next;
  logic [AGE_BITS-1:0] raw_age, raw_age_next;
  logic                debounced, debounced_next;
  logic [AGE_BITS-1:0] hold_age, hold_age_next;
  logic                long_fired, long_fired_next;

  logic                raw;
  logic [AGE_BITS-1:0] hold_inc;
  logic                take_level;
  logic                released;
  logic                long_ev;
  logic                short_ev;

  function automatic logic [AGE_BITS-1:0] age_inc(input logic [AGE_BITS-1:0] a);
    return (a == {AGE_BITS{1'b1}}) ? a : a + AGE_BITS'(1);
  endfunction

  always_comb begin
    raw           = (pin_level == PIN_PRESSED);
    raw_last_next = raw;
    raw_age_next  = (raw != raw_last) ? '0 : age_inc(raw_age);
    hold_inc      = age_inc(hold_age);

    take_level = (raw != debounced) &&
                 (CMP_W'(raw_age_next) >= CMP_W'(regs.debounce_ticks));
    debounced_next = take_level ? raw : debounced;
    // Date the hold from the raw edge, not from acceptance.
    hold_age_next  = take_level ? raw_age_next : hold_inc;
    released       = take_level && !raw;

    long_ev = debounced_next && !long_fired &&
              (CMP_W'(hold_age_next) >= CMP_W'(regs.long_press_ticks));

    short_ev        = released && !long_fired;
    long_fired_next = released ? 1'b0 : (long_fired | long_ev);

    res.pressed     = debounced_next;
    res.short_press = short_ev;
    res.long_press  = long_ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_last   <= 1'b0;
      raw_age    <= '0;
      debounced  <= 1'b0;
      hold_age   <= '0;
      long_fired <= 1'b0;
    end else if (step) begin
      raw_last   <= raw_last_next;
      raw_age    <= raw_age_next;
      debounced  <= debounced_next;
      hold_age   <= hold_age_next;
      long_fired <= long_fired_next;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for the button press classifier: directed script, random gestures, extremes.
module tb;
  import bpc_pkg::*;

  localparam int AGE_BITS    = 16;
  localparam int DRAIN_TICKS = 4;
  localparam int QUIET_LIMIT = 2000;

  localparam logic [AGE_BITS-1:0]  AGE_MAX      = {AGE_BITS{1'b1}};
  localparam logic                 PIN_RELEASED = ~PIN_PRESSED;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TOP_IDX  = {CFG_IDX_W{1'b1}};

  localparam int SEND_IDLE_PCT[4]  = '{0, 85, 0, 31};
  localparam int RECV_STALL_PCT[4] = '{0, 0, 85, 31};

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    logic                  pin;
    logic                  checked;
    result_t               want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst;

  bpc_sample_if sample_ch();
  bpc_result_if result_ch();
  bpc_cfg_if    cfg_ch();

  button_press_classifier_unit #(.AGE_BITS(AGE_BITS)) DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Predictor state and configuration copy
  logic [DEB_W-1:0]    deb_limit;
  logic [LONG_W-1:0]   long_limit;
  logic                raw_down;
  logic [AGE_BITS-1:0] raw_steady;
  logic                level_down;
  logic [AGE_BITS-1:0] held_for;
  logic                long_done;

  result_t     expected_q[$];
  script_row_t script[$];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          errors;
  int          results_seen;
  int          quiet_cycles;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [AGE_BITS-1:0] age_step(input logic [AGE_BITS-1:0] age);
    return (age == AGE_MAX) ? AGE_MAX : age + AGE_BITS'(1);
  endfunction

  function automatic result_t classify_tick(input logic pin);
    logic    down;
    logic    released_now;
    result_t res;
    down         = (pin == PIN_PRESSED);
    released_now = 1'b0;
    res          = '0;
    if (down != raw_down) begin
      raw_down   = down;
      raw_steady = '0;
    end else begin
      raw_steady = age_step(raw_steady);
    end
    held_for = age_step(held_for);
    // accept the new level; the hold is dated from the raw edge
    if (down != level_down && raw_steady >= deb_limit) begin
      level_down   = down;
      held_for     = raw_steady;
      released_now = !down;
    end
    if (level_down && held_for >= long_limit && !long_done) begin
      long_done       = 1'b1;
      res.long_press  = 1'b1;
    end
    if (released_now) begin
      if (long_done) begin
        long_done = 1'b0;
      end else begin
        res.short_press = 1'b1;
      end
    end
    res.pressed = level_down;
    return res;
  endfunction

  function automatic script_row_t row_pin(input logic pin);
    script_row_t row;
    row      = '0;
    row.kind = ROW_SAMPLE;
    row.pin  = pin;
    return row;
  endfunction

  // want is {pressed, short_press, long_press}
  function automatic script_row_t row_pin_chk(input logic pin, input result_t want);
    script_row_t row;
    row         = row_pin(pin);
    row.checked = 1'b1;
    row.want    = want;
    return row;
  endfunction

  function automatic script_row_t row_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] val);
    script_row_t row;
    row       = '0;
    row.kind  = ROW_WRITE;
    row.index = idx;
    row.data  = val;
    return row;
  endfunction

  task automatic flag(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Enter and leave at a falling edge; valid stays high into the next item.
  task automatic send_pin(input logic pin, input logic checked, input result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.pin_level <= pin;
    do @(posedge clk); while (!sample_ch.ready);
    predicted = classify_tick(pin);
    expected_q.push_back(checked ? want : predicted);
    @(negedge clk);
  endtask

  task automatic send_run(input logic pin, input int unsigned count);
    repeat (count) send_pin(pin, 1'b0, '0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    sample_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_TICKS) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_DEBOUNCE_TICKS:   deb_limit  = val[DEB_W-1:0];
      REG_LONG_PRESS_TICKS: long_limit = val[LONG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Presses of random length around the thresholds, bounces and noise.
  task automatic play_gestures(input int unsigned n_items);
    int unsigned sent;
    int unsigned hold;
    int unsigned gap;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0, 1, 2, 3: hold = deb_limit + 1 + $urandom_range(long_limit);
        4, 5:       hold = deb_limit + long_limit + $urandom_range(1, 6);
        6, 7:       hold = $urandom_range(1, deb_limit + 1);
        default: begin
          hold = 0;
          repeat ($urandom_range(1, 8)) begin
            send_pin(1'($urandom_range(1)), 1'b0, '0);
            sent++;
          end
        end
      endcase
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, deb_limit + 1)
                                     : deb_limit + 1 + $urandom_range(3);
      send_run(PIN_PRESSED, hold);
      send_run(PIN_RELEASED, gap);
      sent += hold + gap;
    end
  endtask

  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_q.size() == 0) begin
        flag($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_q.pop_front();
        if (result_ch.pressed !== want.pressed)
          flag($sformatf("result %0d pressed: want %b got %b",
                         results_seen, want.pressed, result_ch.pressed));
        if (result_ch.short_press !== want.short_press)
          flag($sformatf("result %0d short_press: want %b got %b",
                         results_seen, want.short_press, result_ch.short_press));
        if (result_ch.long_press !== want.long_press)
          flag($sformatf("result %0d long_press: want %b got %b",
                         results_seen, want.long_press, result_ch.long_press));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                 = 1'b1;
    sample_ch.valid     = 1'b0;
    sample_ch.pin_level = PIN_RELEASED;
    result_ch.ready     = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    errors              = 0;
    results_seen        = 0;
    quiet_cycles        = 0;
    deb_limit           = DEBOUNCE_RESET;
    long_limit          = LONG_PRESS_RESET;
    raw_down            = 1'b0;
    raw_steady          = '0;
    level_down          = 1'b0;
    held_for            = '0;
    long_done           = 1'b0;

    // reset settings: a short press and a bounce are both filtered
    script.push_back(row_pin_chk(PIN_RELEASED, 3'b000));
    script.push_back(row_pin_chk(PIN_PRESSED,  3'b000));
    script.push_back(row_pin_chk(PIN_RELEASED, 3'b000));
    // zero debounce and zero threshold: accept and fire on the first tick
    script.push_back(row_write(REG_DEBOUNCE_TICKS, 16'd0));
    script.push_back(row_write(REG_LONG_PRESS_TICKS, 16'd0));
    script.push_back(row_pin_chk(PIN_PRESSED,  3'b101));
    script.push_back(row_pin_chk(PIN_PRESSED,  3'b100));
    script.push_back(row_pin_chk(PIN_RELEASED, 3'b000));
    script.push_back(row_pin_chk(PIN_RELEASED, 3'b000));
    // one-tick press gives a short press; a full hold fires long, release is silent
    script.push_back(row_write(REG_LONG_PRESS_TICKS, 16'd3));
    script.push_back(row_pin_chk(PIN_PRESSED,  3'b100));
    script.push_back(row_pin_chk(PIN_RELEASED, 3'b010));
    script.push_back(row_pin_chk(PIN_PRESSED,  3'b100));
    script.push_back(row_pin_chk(PIN_PRESSED,  3'b100));
    script.push_back(row_pin_chk(PIN_PRESSED,  3'b100));
    script.push_back(row_pin_chk(PIN_PRESSED,  3'b101));
    script.push_back(row_pin_chk(PIN_RELEASED, 3'b000));
    // upper data bits drop on the debounce register; spare indexes do nothing
    script.push_back(row_write(REG_DEBOUNCE_TICKS, 16'hFC02));
    script.push_back(row_write(REG_SPARE, 16'h0000));
    script.push_back(row_write(REG_TOP_IDX, 16'hFFFF));
    repeat (4) script.push_back(row_pin(PIN_PRESSED));
    repeat (3) script.push_back(row_pin(PIN_RELEASED));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        write_reg(script[i].index, script[i].data);
      end else begin
        send_pin(script[i].pin, script[i].checked, script[i].want);
      end
    end

    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_DEBOUNCE_TICKS, {6'($urandom), 10'($urandom_range(4))});
      write_reg(REG_LONG_PRESS_TICKS, 16'($urandom_range(1, 12)));
      send_idle_pct  = SEND_IDLE_PCT[phase % 4];
      recv_stall_pct = RECV_STALL_PCT[phase % 4];
      play_gestures(60);
    end

    // extremes: a debounce of 1000 filters a press, largest threshold never fires
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_DEBOUNCE_TICKS, 16'd1000);
    write_reg(REG_LONG_PRESS_TICKS, 16'd60000);
    send_run(PIN_PRESSED, 40);
    send_run(PIN_RELEASED, 10);
    write_reg(REG_DEBOUNCE_TICKS, 16'd0);
    write_reg(REG_LONG_PRESS_TICKS, 16'hFFFF);
    send_run(PIN_PRESSED, 20);
    send_run(PIN_RELEASED, 5);

    sample_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (2 * DRAIN_TICKS) @(negedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
